FILE: hdl/huffman_tree_decoder_assert.svh
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared forms for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// same-cycle implication
`define HTD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("huffman_tree_decoder: check failed");

// next-cycle implication
`define HTD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("huffman_tree_decoder: check failed");

`endif

FILE: hdl/htd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Item types, node layout, register map and table sizing.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MAX_NODES = 512;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int NODE_W    = 1 + SYM_W + 2 * IDX_W;
  localparam int CODE_W    = 8;
  localparam int CNT_W     = 4;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic       KIND_NODE   = 1'b0;
  localparam logic       KIND_DECODE = 1'b1;
  localparam logic       REG_ROOT    = 1'b0;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CODE_W);

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [CODE_W-1:0] code_byte;
    logic [CNT_W-1:0] bit_count;
  } htd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             error;
    logic             last;
  } htd_out_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } htd_node_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             error;
  } htd_res_t;

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < MAX_NODES;
  endfunction

endpackage

FILE: hdl/htd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Node write: written to the node table on acceptance, no result. Decode:
// each code bit on an internal node passes STEP and CHILD; after a symbol
// the root is refetched through FETCH and LATCH, and FLUSH releases the
// last result. A new item is taken only back in IDLE; output stalls can hold
// the walk. FETCH and LATCH wait on the registered node table read. Reset
// clears control, root and walker; the node table is undefined until written.
// ----------------------------------------------------------------------------
module huffman_tree_decoder
  import htd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  htd_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output htd_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LATCH = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_CHILD = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  root_r, root_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  nxt_r, nxt_nxt;
  htd_node_t         here_r, here_nxt;
  logic              hv_r, hv_nxt;
  logic [CODE_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  htd_res_t          pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  htd_out_t          out_r, out_nxt;
  logic              oor_r;

  logic              in_acc;
  logic              cfg_wr;
  logic              out_free;
  logic              can_push;
  logic              consume;
  logic              ram_we;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  next_idx;
  logic [NODE_W-1:0] rd_data;
  htd_node_t         ent;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ROOT) ? CFG_DW'(root_r) : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign can_push  = !pend_v_r || out_free;
  assign ent       = oor_r ? '0 : htd_node_t'(rd_data);
  assign next_idx  = sh_r[CODE_W-1] ? here_r.right : here_r.left;
  assign ram_we    = in_acc && (in_data.kind == KIND_NODE) && idx_in_range(in_data.node_index);

  always_comb begin
    case (state_r)
      S_STEP:  rd_idx = next_idx;
      S_CHILD: rd_idx = nxt_r;
      default: rd_idx = cur_r;
    endcase
  end

  htd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ADDR_W'(in_data.node_index)),
    .wr_data ({in_data.node_is_leaf, in_data.node_symbol,
               in_data.left_index, in_data.right_index}),
    .rd_addr (ADDR_W'(rd_idx)),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    here_nxt      = here_r;
    hv_nxt        = hv_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    consume       = 1'b0;

    if (cfg_wr && (paddr[2] == REG_ROOT)) begin
      root_nxt = pwdata[IDX_W-1:0];
      cur_nxt  = pwdata[IDX_W-1:0];
      hv_nxt   = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_NODE) begin
            cur_nxt = root_r;
            hv_nxt  = 1'b0;
          end else begin
            sh_nxt  = in_data.code_byte;
            cnt_nxt = (in_data.bit_count > CNT_MAX) ? CNT_MAX : in_data.bit_count;
            if (in_data.bit_count != '0) begin
              state_nxt = hv_r ? S_STEP : S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        here_nxt  = ent;
        hv_nxt    = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (here_r.leaf) begin
          if (can_push) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{symbol: pend_r.symbol, error: pend_r.error, last: 1'b0};
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{symbol: '0, error: 1'b1};
            cur_nxt    = root_r;
            hv_nxt     = 1'b0;
            consume    = 1'b1;
          end
        end else begin
          nxt_nxt   = next_idx;
          state_nxt = S_CHILD;
        end
      end
      S_CHILD: begin
        if (ent.leaf) begin
          if (can_push) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{symbol: pend_r.symbol, error: pend_r.error, last: 1'b0};
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{symbol: ent.symbol, error: 1'b0};
            cur_nxt    = root_r;
            hv_nxt     = 1'b0;
            consume    = 1'b1;
          end
        end else begin
          cur_nxt  = nxt_r;
          here_nxt = ent;
          hv_nxt   = 1'b1;
          consume  = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{symbol: pend_r.symbol, error: pend_r.error, last: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (consume) begin
      sh_nxt  = {sh_r[CODE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        state_nxt = S_FLUSH;
      end else begin
        state_nxt = hv_nxt ? S_STEP : S_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      cur_r       <= '0;
      hv_r        <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      cur_r       <= cur_nxt;
      hv_r        <= hv_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt_r  <= nxt_nxt;
    here_r <= here_nxt;
    sh_r   <= sh_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    oor_r  <= !idx_in_range(rd_idx);
  end

endmodule

FILE: hdl/htd_checker.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder port checker
// Concurrent checks on the item channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_assert.svh"

module htd_checker
  import htd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input htd_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input htd_out_t out_data
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  `HTD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_data))
  `HTD_ASSERT_NXT(a_decode_busy, clk, rst_n,
                  in_acc && (in_data.kind == KIND_DECODE) && (in_data.bit_count != '0), in_stall)
  `HTD_ASSERT_NXT(a_node_quick, clk, rst_n, in_acc && (in_data.kind == KIND_NODE), !in_stall)
  `HTD_ASSERT_IMP(a_err_sym, clk, rst_n, out_valid && out_data.error, out_data.symbol == '0)

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
